FILE: hdl/turing_machine_step_engine_assert.svh
// Assertion macros for the Turing machine step engine checker.
// Needs clk and arst_n in the scope of each use.
`ifndef TURING_MACHINE_STEP_ENGINE_ASSERT_SVH
`define TURING_MACHINE_STEP_ENGINE_ASSERT_SVH

// same-cycle implication
`define TMSE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tmse assertion failed");

// next-cycle implication
`define TMSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmse assertion failed");

`endif

FILE: hdl/tmse_pkg.sv
// Shared types and constants of the Turing machine step engine.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package tmse_pkg;

	localparam int STATE_W   = 4;
	localparam int SYM_W     = 3;
	localparam int MOVE_W    = 2;
	localparam int CMD_W     = 3;
	localparam int STAT_W    = 3;
	localparam int POS_W     = 10;
	localparam int LEN_W     = POS_W + 1;
	localparam int STATE_COUNT = 1 << STATE_W;
	localparam int SYMBOL_COUNT = 1 << SYM_W;
	localparam int TAPE_DEPTH  = 1 << POS_W;
	localparam int RULE_W    = SYM_W + MOVE_W + STATE_W;
	localparam int RIDX_W    = STATE_W + SYM_W;

	localparam logic [CMD_W-1:0] CMD_SET_ENTRY    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE_ENTRY = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR_TABLE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOAD_CELL    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STEP         = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ_CELL    = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_HALTED   = 3'd1;
	localparam logic [STAT_W-1:0] STAT_NO_ROW   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_MISSING  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd4;

	localparam logic [MOVE_W-1:0] MOVE_STAY  = 2'd0;
	localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd1;
	localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd2;

	localparam logic [0:0] CFG_HALT_STATE   = 1'b0;
	localparam logic [0:0] CFG_BLANK_SYMBOL = 1'b1;

	localparam logic [STATE_W-1:0] HALT_RESET = STATE_W'(STATE_COUNT - 1);
	localparam logic [POS_W-1:0]   HEAD_LAST  = POS_W'(TAPE_DEPTH - 1);
	localparam logic [LEN_W-1:0]   LEN_MAX    = LEN_W'(TAPE_DEPTH);

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [STATE_W-1:0] entry_state;
		logic [SYM_W-1:0]   entry_symbol;
		logic [SYM_W-1:0]   write_symbol;
		logic [MOVE_W-1:0]  move_code;
		logic [STATE_W-1:0] next_state;
		logic [POS_W-1:0]   cell_position;
		logic [SYM_W-1:0]   cell_symbol;
		logic               last_cell;
	} tm_in_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [STATE_W-1:0] machine_state;
		logic [POS_W-1:0]   head_position;
		logic [SYM_W-1:0]   symbol_out;
		logic [LEN_W-1:0]   tape_length;
	} tm_out_t;

	typedef struct packed {
		logic [SYM_W-1:0]   wsym;
		logic [MOVE_W-1:0]  move;
		logic [STATE_W-1:0] nxt;
	} rule_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_LOOKUP,
		FSM_EXEC
	} tm_fsm_t;

	typedef struct packed {
		logic in_ready;
		logic tape_re;
		logic rule_re;
		logic commit;
	} tm_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/turing_machine_step_engine.sv
// Single-tape Turing machine step engine with transition table and tape memories.
// Depends on tmse_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   in_valid/in_ready/in_data carry one command transaction (table edit, tape load,
//   step, tape read); out_valid/out_ready/out_data return exactly one result per
//   command, in order.
//   Every command passes through the tape memory read at the accepting edge,
//   the dependent transition table read, then the write-back, which loads the
//   result register and waits while a held result is not taken. One command is in
//   flight at a time, so a new transaction is accepted only after the previous write-back.
//   cfg_we/cfg_index/cfg_data write halt_state (index 0) and blank_symbol (index 1);
//   write them only while no command is in flight.
//   Reset: all table entries invalid, tape length, head and state zero, halt state
//   15, blank symbol 0. Tape and table contents are undefined until written.
//   Receiver stall: the result register holds; the next command is still accepted
//   and worked up to its write-back, which waits until the result is taken.
module turing_machine_step_engine
	import tmse_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [0:0]           cfg_index,
	input  wire logic [STATE_W-1:0]   cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire tm_in_t               in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output tm_out_t                   out_data
);

	tm_fsm_t fsm_q, fsm_d;
	tm_ctrl_t ctrl;

	logic [STATE_W-1:0] halt_q;
	logic [SYM_W-1:0]   blank_q;
	logic [STATE_W-1:0] state_q, state_d;
	logic [POS_W-1:0]   head_q, head_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [STATE_COUNT-1:0][SYMBOL_COUNT-1:0] valid_q, valid_d;

	tm_in_t item_q;
	logic   in_fire, out_free;

	// memories
	logic [SYM_W-1:0]  tape_mem [TAPE_DEPTH];
	logic [RULE_W-1:0] rule_mem [STATE_COUNT*SYMBOL_COUNT];
	logic [SYM_W-1:0]  tape_rd_q;
	rule_t             rule_rd_q;
	logic [POS_W-1:0]  tape_raddr, tape_waddr;
	logic [SYM_W-1:0]  tape_wdata;
	logic              tape_we, rule_we;
	logic [RIDX_W-1:0] rule_raddr, rule_waddr;

	// lookup stage
	logic [LEN_W-1:0] look_pos;
	logic [SYM_W-1:0] cell_sym;
	logic [SYM_W-1:0] sym_s1;
	logic             row_any_s1, hit_s1;

	tm_out_t result;

	assign in_fire  = in_valid && ctrl.in_ready;
	assign out_free = !out_valid || out_ready;
	assign in_ready = ctrl.in_ready;

	// next state
	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			FSM_IDLE:   if (in_valid) fsm_d = FSM_LOOKUP;
			FSM_LOOKUP: fsm_d = FSM_EXEC;
			FSM_EXEC:   if (out_free) fsm_d = FSM_IDLE;
			default:    fsm_d = FSM_IDLE;
		endcase
	end

	// controls
	always_comb begin
		ctrl = '0;
		unique case (fsm_q)
			FSM_IDLE: begin
				ctrl.in_ready = 1'b1;
				ctrl.tape_re  = in_valid;
			end
			FSM_LOOKUP: ctrl.rule_re = 1'b1;
			FSM_EXEC:   ctrl.commit  = out_free;
			default:    ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= FSM_IDLE;
		end else begin
			fsm_q <= fsm_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_q  <= HALT_RESET;
			blank_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALT_STATE:   halt_q  <= cfg_data;
				CFG_BLANK_SYMBOL: blank_q <= cfg_data[SYM_W-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_data;
		end
	end

	// tape memory
	assign tape_raddr = (in_data.command == CMD_READ_CELL) ? in_data.cell_position : head_q;

	always_ff @(posedge clk) begin
		if (tape_we) begin
			tape_mem[tape_waddr] <= tape_wdata;
		end
		if (ctrl.tape_re) begin
			tape_rd_q <= tape_mem[tape_raddr];
		end
	end

	// blank past the tape end, then fetch the entry for (state, symbol)
	assign look_pos   = (item_q.command == CMD_READ_CELL) ? {1'b0, item_q.cell_position}
	                                                      : {1'b0, head_q};
	assign cell_sym   = (look_pos >= len_q) ? blank_q : tape_rd_q;
	assign rule_raddr = {state_q, cell_sym};

	always_ff @(posedge clk) begin
		if (rule_we) begin
			rule_mem[rule_waddr] <= {item_q.write_symbol, item_q.move_code, item_q.next_state};
		end
		if (ctrl.rule_re) begin
			rule_rd_q <= rule_t'(rule_mem[rule_raddr]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rule_re) begin
			sym_s1     <= cell_sym;
			row_any_s1 <= |valid_q[state_q];
			hit_s1     <= valid_q[state_q][cell_sym];
		end
	end

	// execute and write back
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		len_d      = len_q;
		valid_d    = valid_q;
		tape_we    = 1'b0;
		rule_we    = 1'b0;
		tape_waddr = head_q;
		tape_wdata = rule_rd_q.wsym;
		rule_waddr = {item_q.entry_state, item_q.entry_symbol};
		result     = '0;
		case (item_q.command)
			CMD_SET_ENTRY: begin
				rule_we = ctrl.commit;
				valid_d[item_q.entry_state][item_q.entry_symbol] = 1'b1;
			end
			CMD_REMOVE_ENTRY: begin
				valid_d[item_q.entry_state][item_q.entry_symbol] = 1'b0;
			end
			CMD_CLEAR_TABLE: begin
				valid_d = '0;
			end
			CMD_LOAD_CELL: begin
				tape_we    = ctrl.commit;
				tape_waddr = item_q.cell_position;
				tape_wdata = item_q.cell_symbol;
				if (item_q.last_cell) begin
					len_d   = {1'b0, item_q.cell_position} + LEN_W'(1);
					head_d  = '0;
					state_d = '0;
				end
			end
			CMD_STEP: begin
				result.symbol_out = sym_s1;
				if (state_q == halt_q) begin
					result.status = STAT_HALTED;
				end else if (!row_any_s1) begin
					result.status = STAT_NO_ROW;
				end else if (!hit_s1) begin
					result.status = STAT_MISSING;
				end else begin
					tape_we           = ctrl.commit;
					result.symbol_out = rule_rd_q.wsym;
					if ({1'b0, head_q} >= len_q) begin
						len_d = {1'b0, head_q} + LEN_W'(1);
					end
					case (rule_rd_q.move)
						MOVE_RIGHT: begin
							if (head_q != HEAD_LAST) head_d = head_q + POS_W'(1);
							else result.status = STAT_OVERFLOW;
						end
						MOVE_LEFT: begin
							if (head_q != '0) head_d = head_q - POS_W'(1);
						end
						default: ;
					endcase
					state_d = rule_rd_q.nxt;
				end
			end
			CMD_READ_CELL: begin
				result.symbol_out = sym_s1;
			end
			default: ;
		endcase
		result.machine_state = state_d;
		result.head_position = head_d;
		result.tape_length   = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			head_q  <= '0;
			len_q   <= '0;
			valid_q <= '0;
		end else if (ctrl.commit) begin
			state_q <= state_d;
			head_q  <= head_d;
			len_q   <= len_d;
			valid_q <= valid_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctrl.commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			out_data <= result;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/tmse_checker.sv
// Port-level checker for the Turing machine step engine, bound to the top level.
// Depends on tmse_pkg and turing_machine_step_engine_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "turing_machine_step_engine_assert.svh"

module tmse_checker
	import tmse_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    in_valid,
	input wire logic    in_ready,
	input wire logic    out_valid,
	input wire logic    out_ready,
	input wire tm_out_t out_data
);

	// a held result keeps its payload
	`TMSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// one command in flight: busy right after a transaction is taken
	`TMSE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// overflow only reported with the head parked on the last cell
	`TMSE_ASSERT_NOW(a_overflow_head, out_valid && out_data.status == STAT_OVERFLOW,
		out_data.head_position == HEAD_LAST)

	// tape length never exceeds the tape
	`TMSE_ASSERT_NOW(a_len_bound, out_valid, out_data.tape_length <= LEN_MAX)

endmodule

bind turing_machine_step_engine tmse_checker u_tmse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
